// ----- rtl/core/u8csv_pkg.sv -----
// Shared types and constants of the UTF-8 sanitizer and CSV quoter.
`default_nettype none

package u8csv_pkg;

   // Most output bytes one input byte can cause
   localparam int MaxResults = 7;
   localparam int CountW     = 3;

   // Characters
   localparam logic [7:0] CharQuote = 8'h22;
   localparam logic [7:0] CharQmark = 8'h3F;
   localparam logic [7:0] CharSpace = 8'h20;
   localparam logic [7:0] CharDel   = 8'h7F;

   // Lead byte and second byte limits
   localparam logic [7:0] LeadMin2 = 8'hC2;
   localparam logic [7:0] LeadMax4 = 8'hF4;
   localparam logic [7:0] LeadE0   = 8'hE0;
   localparam logic [7:0] LeadED   = 8'hED;
   localparam logic [7:0] LeadF0   = 8'hF0;
   localparam logic [7:0] SecA0    = 8'hA0;
   localparam logic [7:0] Sec90    = 8'h90;

   // Byte class masks
   localparam logic [7:0] MaskC0 = 8'hC0;
   localparam logic [7:0] MaskE0 = 8'hE0;
   localparam logic [7:0] MaskF0 = 8'hF0;
   localparam logic [7:0] MaskF8 = 8'hF8;
   localparam logic [7:0] Cont80 = 8'h80;

   // Sequence lengths
   localparam logic [2:0] SeqNone = 3'd0;
   localparam logic [2:0] SeqTwo  = 3'd2;
   localparam logic [2:0] SeqThree = 3'd3;
   localparam logic [2:0] SeqFour = 3'd4;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       field_last;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       run_last;
      logic       field_done;
   } rsp_type;

   // All output bytes caused by one input byte
   typedef struct packed {
      logic [MaxResults-1:0][7:0] bytes;
      logic [CountW-1:0]          count;
      logic                       done;
   } job_type;

   // Queue head as seen by the back end
   typedef struct packed {
      job_type head;
      logic    empty;
   } head_type;

endpackage

`default_nettype wire

// ----- rtl/core/u8csv_front.sv -----
// Front end: UTF-8 checking, sequence holding and expansion into an output job.
`default_nettype none

module u8csv_front (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   input  wire u8csv_pkg::req_type req_data,
   input  wire logic               q_full,
   output logic                    full,
   output logic                    job_push,
   output u8csv_pkg::job_type      job_data
);
   import u8csv_pkg::*;

   typedef struct packed {
      logic [MaxResults-1:0][7:0] bytes;
      logic [CountW-1:0]          count;
      logic                       opened;
      logic [7:0]                 lead;
      logic [7:0]                 second;
      logic [7:0]                 third;
      logic [1:0]                 held;
      logic [2:0]                 len;
   } work_type;

   // Append one byte to the job
   function automatic work_type put_raw(work_type a, logic [7:0] b);
      work_type r;
      r = a;
      if (r.count != CountW'(MaxResults)) begin
         r.bytes[r.count] = b;
         r.count = r.count + 1'b1;
      end
      return r;
   endfunction

   // Append a kept byte, opening the quote and doubling quotes
   function automatic work_type put_kept(work_type a, logic [7:0] b);
      work_type r;
      r = a;
      if (!r.opened) begin
         r = put_raw(r, CharQuote);
         r.opened = 1'b1;
      end
      r = put_raw(r, b);
      if (b == CharQuote) begin
         r = put_raw(r, CharQuote);
      end
      return r;
   endfunction

   // Every held byte becomes a question mark
   function automatic work_type drop_held(work_type a);
      work_type r;
      r = a;
      for (int k = 0; k < 3; k++) begin
         if (2'(k) < a.held) begin
            r = put_kept(r, CharQmark);
         end
      end
      r.held = 2'd0;
      r.len  = SeqNone;
      return r;
   endfunction

   // Byte seen with nothing held
   function automatic work_type take_fresh(work_type a, logic [7:0] b);
      work_type   r;
      logic [2:0] len;
      r   = a;
      len = SeqNone;
      if (!b[7]) begin
         if (b != 8'h00) begin
            if (b < CharSpace || b == CharDel) begin
               r = put_kept(r, CharSpace);
            end else begin
               r = put_kept(r, b);
            end
         end
      end else begin
         priority if ((b & MaskE0) == MaskC0) begin
            len = (b >= LeadMin2) ? SeqTwo : SeqNone;
         end else if ((b & MaskF0) == MaskE0) begin
            len = SeqThree;
         end else if ((b & MaskF8) == MaskF0) begin
            len = (b <= LeadMax4) ? SeqFour : SeqNone;
         end else begin
            len = SeqNone;
         end
         if (len == SeqNone) begin
            r = put_kept(r, CharQmark);
         end else begin
            r.lead = b;
            r.held = 2'd1;
            r.len  = len;
         end
      end
      return r;
   endfunction

   logic [7:0] held_lead_ff,   held_lead_in;
   logic [7:0] held_second_ff, held_second_in;
   logic [7:0] held_third_ff,  held_third_in;
   logic [1:0] held_count_ff,  held_count_in;
   logic [2:0] exp_len_ff,     exp_len_in;
   logic       opened_ff,      opened_in;

   logic       accept;
   logic [7:0] b;
   logic       sec_ok;
   work_type   w;

   assign full   = q_full;
   assign accept = push && !q_full;
   assign b      = req_data.data_byte;

   // Second byte range check for the special leads
   always_comb begin
      sec_ok = 1'b1;
      if (held_lead_ff == LeadE0 && b <  SecA0) sec_ok = 1'b0;
      if (held_lead_ff == LeadED && b >= SecA0) sec_ok = 1'b0;
      if (held_lead_ff == LeadF0 && b <  Sec90) sec_ok = 1'b0;
      if (held_lead_ff == LeadMax4 && b >= Sec90) sec_ok = 1'b0;
   end

   // Classify the byte and build its job
   always_comb begin
      w        = '0;
      w.opened = opened_ff;
      w.lead   = held_lead_ff;
      w.second = held_second_ff;
      w.third  = held_third_ff;
      w.held   = held_count_ff;
      w.len    = exp_len_ff;
      priority if (held_count_ff == 2'd0) begin
         w = take_fresh(w, b);
      end else if ((b & MaskC0) != Cont80) begin
         w = take_fresh(drop_held(w), b);
      end else if (held_count_ff == 2'd1 && !sec_ok) begin
         w = take_fresh(drop_held(w), b);
      end else if ({1'b0, held_count_ff} + 3'd1 == exp_len_ff) begin
         w = put_kept(w, held_lead_ff);
         if (held_count_ff >= 2'd2) w = put_kept(w, held_second_ff);
         if (held_count_ff == 2'd3) w = put_kept(w, held_third_ff);
         w = put_kept(w, b);
         w.held = 2'd0;
         w.len  = SeqNone;
      end else begin
         if (held_count_ff == 2'd1) begin
            w.second = b;
         end else begin
            w.third = b;
         end
         w.held = held_count_ff + 2'd1;
      end
      if (req_data.field_last) begin
         w = drop_held(w);
         if (w.opened) begin
            w = put_raw(w, CharQuote);
         end
      end
   end

   // Job handed to the queue
   assign job_push       = accept && (w.count != '0);
   assign job_data.bytes = w.bytes;
   assign job_data.count = w.count;
   assign job_data.done  = req_data.field_last && w.opened;

   // Next state; the end of a field returns everything to reset
   always_comb begin
      held_lead_in   = held_lead_ff;
      held_second_in = held_second_ff;
      held_third_in  = held_third_ff;
      held_count_in  = held_count_ff;
      exp_len_in     = exp_len_ff;
      opened_in      = opened_ff;
      if (accept) begin
         if (req_data.field_last) begin
            held_lead_in   = '0;
            held_second_in = '0;
            held_third_in  = '0;
            held_count_in  = '0;
            exp_len_in     = SeqNone;
            opened_in      = 1'b0;
         end else begin
            held_lead_in   = w.lead;
            held_second_in = w.second;
            held_third_in  = w.third;
            held_count_in  = w.held;
            exp_len_in     = w.len;
            opened_in      = w.opened;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_lead_ff   <= '0;
         held_second_ff <= '0;
         held_third_ff  <= '0;
         held_count_ff  <= '0;
         exp_len_ff     <= SeqNone;
         opened_ff      <= 1'b0;
      end else begin
         held_lead_ff   <= held_lead_in;
         held_second_ff <= held_second_in;
         held_third_ff  <= held_third_in;
         held_count_ff  <= held_count_in;
         exp_len_ff     <= exp_len_in;
         opened_ff      <= opened_in;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/core/u8csv_jobq.sv -----
// Short job queue between the front end and the back end.
`default_nettype none

module u8csv_jobq #(
   parameter int Depth = 2
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               wr_en,
   input  wire u8csv_pkg::job_type wr_data,
   input  wire logic               rd_en,
   output u8csv_pkg::head_type     head,
   output logic                    q_full
);
   import u8csv_pkg::*;

   localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW = $clog2(Depth + 1);

   job_type         mem_ff [Depth];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff,  count_in;
   logic            do_wr, do_rd;

   assign q_full     = (count_ff == CntW'(Depth));
   assign head.empty = (count_ff == '0);
   assign head.head  = mem_ff[rd_ptr_ff];
   assign do_wr      = wr_en && !q_full;
   assign do_rd      = rd_en && !head.empty;

   // Pointer and count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_wr && !do_rd) begin
         count_in = count_ff + 1'b1;
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Job storage
   always_ff @(posedge clock) begin
      if (do_wr) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/core/u8csv_back.sv -----
// Back end: sends the bytes of the head job one per cycle while pop is high.
`default_nettype none

module u8csv_back (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire u8csv_pkg::head_type head,
   output logic                     job_pop,
   output logic                     empty,
   input  wire logic                pop,
   output u8csv_pkg::rsp_type       rsp_data
);
   import u8csv_pkg::*;

   logic [CountW-1:0] idx_ff, idx_in;
   logic              at_last;
   logic              take;

   assign empty   = head.empty;
   assign at_last = (idx_ff == head.head.count - 1'b1);
   assign take    = pop && !head.empty;
   assign job_pop = take && at_last;

   // Current result
   assign rsp_data.out_byte   = head.head.bytes[idx_ff];
   assign rsp_data.run_last   = at_last;
   assign rsp_data.field_done = at_last && head.head.done;

   // Byte index within the head job
   always_comb begin
      idx_in = idx_ff;
      if (take) begin
         idx_in = at_last ? '0 : idx_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
      end else begin
         idx_ff <= idx_in;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/core/utf8_sanitize_csv_quote_top.sv -----
// Top level of the UTF-8 sanitizer and CSV field quoter.
//
// Input channel: one raw byte of a text field per transaction, with
// field_last on the final byte. A transaction is taken at a clock edge with
// push high and full low. Result channel: bytes of the quoted, sanitized
// field; the oldest result is shown while empty is low and taken when pop
// is high. run_last marks the last result of an input byte, field_done the
// closing quote.
// A byte's results are queued when it is taken and shown after earlier ones.
// Throughput: the front end takes one byte per cycle while full is low; the
// back end sends one result per cycle while pop is high, so a byte causing
// k results (at most 7) holds the back end until all k are taken. The job
// queue of QUEUE_DEPTH entries between them lets the input keep flowing until it fills; full is high only then.
// Bytes that cause no result (NUL, held sequence bytes) never enter the queue.
// Reset clears the held sequence, the quote flag and the queue.
// When the receiver stalls, the shown result holds and the queue fills,
// after which full rises and holds off the sender.
`default_nettype none

module utf8_sanitize_csv_quote_top #(
   parameter int QUEUE_DEPTH = 2
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   input  wire u8csv_pkg::req_type req_data,
   output logic                    full,
   output logic                    empty,
   input  wire logic               pop,
   output u8csv_pkg::rsp_type      rsp_data
);
   import u8csv_pkg::*;

   logic     q_full;
   logic     job_push;
   job_type  job_data;
   logic     job_pop;
   head_type head;

   u8csv_front u_front (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .req_data (req_data),
      .q_full   (q_full),
      .full     (full),
      .job_push (job_push),
      .job_data (job_data)
   );

   u8csv_jobq #(
      .Depth (QUEUE_DEPTH)
   ) u_jobq (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (job_push),
      .wr_data (job_data),
      .rd_en   (job_pop),
      .head    (head),
      .q_full  (q_full)
   );

   u8csv_back u_back (
      .clock    (clock),
      .reset    (reset),
      .head     (head),
      .job_pop  (job_pop),
      .empty    (empty),
      .pop      (pop),
      .rsp_data (rsp_data)
   );

endmodule

`default_nettype wire

// ----- rtl/core/u8csv_checker.sv -----
// Port-level checker for the UTF-8 sanitizer and its bind to the top level.
`default_nettype none

module u8csv_checker (
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               push,
   input wire u8csv_pkg::req_type req_data,
   input wire logic               full,
   input wire logic               empty,
   input wire logic               pop,
   input wire u8csv_pkg::rsp_type rsp_data
);
   import u8csv_pkg::*;

   // A shown result that is not taken stays put
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> (!empty && $stable(rsp_data)))
      else $error("result changed while stalled");

   // The closing quote ends the run of its byte
   a_done: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_data.field_done) |->
         (rsp_data.run_last && rsp_data.out_byte == CharQuote))
      else $error("field_done on a non-closing result");

   // Nothing to send and nothing taken keeps the output empty
   a_no_invent: assert property (@(posedge clock) disable iff (reset)
      (empty && !(push && !full)) |=> empty)
      else $error("result appeared without a transaction");

   // Reset leaves both sides idle
   a_reset: assert property (@(posedge clock)
      reset |=> (empty && !full))
      else $error("not idle after reset");

endmodule

bind utf8_sanitize_csv_quote_top u8csv_checker u_checker (
   .clock    (clock),
   .reset    (reset),
   .push     (push),
   .req_data (req_data),
   .full     (full),
   .empty    (empty),
   .pop      (pop),
   .rsp_data (rsp_data)
);

`default_nettype wire

// ----- verif/utf8_sanitize_csv_quote_top_tb.sv -----
// Self-checking testbench of the UTF-8 sanitizer and CSV field quoter.
`default_nettype none

module utf8_sanitize_csv_quote_top_tb;
   import u8csv_pkg::*;

   localparam int ResetCycles   = 12;
   localparam int WatchdogLimit = 3000;
   localparam int HoldOffCycles = 300;
   localparam int DrainCycles   = 8;

   // Clock, reset and DUT ports
   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    push  = 1'b0;
   logic    pop   = 1'b0;
   req_type req_data = '0;
   logic    full;
   logic    empty;
   rsp_type rsp_data;

   always #1 clock = ~clock;

   utf8_sanitize_csv_quote_top u_top (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .req_data (req_data),
      .full     (full),
      .empty    (empty),
      .pop      (pop),
      .rsp_data (rsp_data)
   );

   // Run bookkeeping
   int errors        = 0;
   int bytes_sent    = 0;
   int fields_sent   = 0;
   int bytes_checked = 0;
   int stall_cycles  = 0;
   int tx_idle_pct   = 0;
   int rx_idle_pct   = 0;
   int hold_requests = 0;
   int holds_served  = 0;
   int rx_hold_left  = 0;

   // Predictor state: partially received sequence and quote status
   logic [7:0] seq_lead;
   logic [7:0] seq_second;
   logic [7:0] seq_third;
   logic [1:0] seq_held;
   logic [2:0] seq_len;
   logic       quote_open;

   rsp_type step_bytes[$];     // results of the byte being predicted
   rsp_type quoted_out_q[$];   // results still to come out of the DUT
   logic [7:0] field_buf[$];   // raw bytes of the next random field

   function automatic void clear_field_state();
      seq_lead   = '0;
      seq_second = '0;
      seq_third  = '0;
      seq_held   = '0;
      seq_len    = SeqNone;
      quote_open = 1'b0;
   endfunction

   function automatic void emit_raw(input logic [7:0] b, input logic done);
      rsp_type r;
      r.out_byte   = b;
      r.run_last   = 1'b0;
      r.field_done = done;
      if (step_bytes.size() < MaxResults)
         step_bytes = {step_bytes, r};
   endfunction

   // Kept byte: opening quote first if needed, quotes doubled
   function automatic void emit_kept(input logic [7:0] b);
      if (!quote_open) begin
         emit_raw(CharQuote, 1'b0);
         quote_open = 1'b1;
      end
      emit_raw(b, 1'b0);
      if (b == CharQuote)
         emit_raw(CharQuote, 1'b0);
   endfunction

   function automatic void flush_held();
      for (int k = 0; k < seq_held; k++)
         emit_kept(CharQmark);
      seq_held = '0;
      seq_len  = SeqNone;
   endfunction

   // Byte seen with nothing held
   function automatic void start_fresh(input logic [7:0] b);
      logic [2:0] len;
      len = SeqNone;
      if (b < Cont80) begin
         if (b == 8'h00)
            return;
         if (b < CharSpace || b == CharDel)
            emit_kept(CharSpace);
         else
            emit_kept(b);
         return;
      end
      if ((b & MaskE0) == MaskC0)
         len = (b >= LeadMin2) ? SeqTwo : SeqNone;
      else if ((b & MaskF0) == MaskE0)
         len = SeqThree;
      else if ((b & MaskF8) == MaskF0)
         len = (b <= LeadMax4) ? SeqFour : SeqNone;
      if (len == SeqNone) begin
         emit_kept(CharQmark);
      end else begin
         seq_lead = b;
         seq_held = 2'd1;
         seq_len  = len;
      end
   endfunction

   // Overlong and surrogate/out-of-range checks on the second byte
   function automatic logic second_ok(input logic [7:0] b);
      if (seq_lead == LeadE0 && b < SecA0) return 1'b0;
      if (seq_lead == LeadED && b >= SecA0) return 1'b0;
      if (seq_lead == LeadF0 && b < Sec90) return 1'b0;
      if (seq_lead == LeadMax4 && b >= Sec90) return 1'b0;
      return 1'b1;
   endfunction

   // Expected results of one accepted input transaction
   function automatic void sanitize_byte(input req_type r);
      logic [7:0] b;
      b = r.data_byte;
      step_bytes.delete();
      if (seq_held == 0) begin
         start_fresh(b);
      end else if ((b & MaskC0) != Cont80) begin
         flush_held();
         start_fresh(b);
      end else if (seq_held == 1 && !second_ok(b)) begin
         flush_held();
         start_fresh(b);
      end else if (seq_held + 1 == seq_len) begin
         emit_kept(seq_lead);
         if (seq_held >= 2) emit_kept(seq_second);
         if (seq_held >= 3) emit_kept(seq_third);
         emit_kept(b);
         seq_held = '0;
         seq_len  = SeqNone;
      end else begin
         if (seq_held == 1)
            seq_second = b;
         else
            seq_third = b;
         seq_held++;
      end
      if (r.field_last) begin
         flush_held();
         if (quote_open)
            emit_raw(CharQuote, 1'b1);
         clear_field_state();
      end
      if (step_bytes.size() > 0)
         step_bytes[step_bytes.size()-1].run_last = 1'b1;
      foreach (step_bytes[i])
         quoted_out_q = {quoted_out_q, step_bytes[i]};
   endfunction

   // Offer one byte, with random idle cycles before it
   task automatic send_byte(input logic [7:0] b, input logic last);
      while ($urandom_range(99) < tx_idle_pct) begin
         push <= 1'b0;
         @(posedge clock);
      end
      push     <= 1'b1;
      req_data <= '{data_byte: b, field_last: last};
      do
         @(posedge clock);
      while (full);
      sanitize_byte('{data_byte: b, field_last: last});
      bytes_sent++;
      if (last)
         fields_sent++;
   endtask

   task automatic wait_drained();
      while (quoted_out_q.size() != 0)
         @(posedge clock);
   endtask

   function automatic logic [7:0] rand_cont();
      return 8'($urandom_range(8'h80, 8'hBF));
   endfunction

   // Append one raw byte to the field being built
   function automatic void add_byte(input logic [7:0] b);
      field_buf = {field_buf, b};
   endfunction

   // One piece of field content, mostly well formed
   task automatic add_segment();
      logic [7:0] lead;
      int         len;
      case ($urandom_range(11))
         0, 1, 2, 3: begin
            if ($urandom_range(5) == 0)
               add_byte(CharQuote);
            else
               add_byte(8'($urandom_range(8'h20, 8'h7E)));
         end
         4: begin
            case ($urandom_range(2))
               0: add_byte(8'h00);
               1: add_byte(8'($urandom_range(8'h01, 8'h1F)));
               default: add_byte(CharDel);
            endcase
         end
         5: begin
            add_byte(8'($urandom_range(LeadMin2, 8'hDF)));
            add_byte(rand_cont());
         end
         6: begin
            lead = 8'($urandom_range(LeadE0, 8'hEF));
            add_byte(lead);
            if (lead == LeadE0)
               add_byte(8'($urandom_range(SecA0, 8'hBF)));
            else if (lead == LeadED)
               add_byte(8'($urandom_range(Cont80, 8'h9F)));
            else
               add_byte(rand_cont());
            add_byte(rand_cont());
         end
         7: begin
            lead = 8'($urandom_range(LeadF0, LeadMax4));
            add_byte(lead);
            if (lead == LeadF0)
               add_byte(8'($urandom_range(Sec90, 8'hBF)));
            else if (lead == LeadMax4)
               add_byte(8'($urandom_range(Cont80, 8'h8F)));
            else
               add_byte(rand_cont());
            add_byte(rand_cont());
            add_byte(rand_cont());
         end
         8: begin
            // sequence cut short
            len = $urandom_range(2, 4);
            case (len)
               2: add_byte(8'($urandom_range(LeadMin2, 8'hDF)));
               3: add_byte(8'($urandom_range(8'hE1, 8'hEC)));
               default: add_byte(8'($urandom_range(8'hF1, 8'hF3)));
            endcase
            repeat ($urandom_range(0, len - 2))
               add_byte(rand_cont());
         end
         9: begin
            // second byte outside the lead's allowed range
            case ($urandom_range(3))
               0: begin
                  add_byte(LeadE0);
                  add_byte(8'($urandom_range(Cont80, 8'h9F)));
               end
               1: begin
                  add_byte(LeadED);
                  add_byte(8'($urandom_range(SecA0, 8'hBF)));
               end
               2: begin
                  add_byte(LeadF0);
                  add_byte(8'($urandom_range(Cont80, 8'h8F)));
               end
               default: begin
                  add_byte(LeadMax4);
                  add_byte(8'($urandom_range(Sec90, 8'hBF)));
               end
            endcase
            if ($urandom_range(1)) add_byte(rand_cont());
         end
         default: begin
            case ($urandom_range(2))
               0: add_byte(8'($urandom_range(0, 255)));
               1: add_byte(8'($urandom_range(Cont80, 8'hC1)));
               default: add_byte(8'($urandom_range(8'hF5, 8'hFF)));
            endcase
         end
      endcase
   endtask

   task automatic send_random_field();
      field_buf.delete();
      if ($urandom_range(11) == 0) begin
         // field of NUL bytes only
         repeat ($urandom_range(1, 3)) add_byte(8'h00);
      end else begin
         repeat ($urandom_range(1, 6)) add_segment();
      end
      foreach (field_buf[i])
         send_byte(field_buf[i], i == field_buf.size() - 1);
   endtask

   // Field edges, every byte class and malformed-sequence cases
   task automatic test_directed();
      tx_idle_pct = 0;
      rx_idle_pct = 0;
      // three held bytes dropped ahead of a doubled quote: largest burst
      send_byte(LeadF0, 1'b0);
      send_byte(Sec90, 1'b0);
      send_byte(Cont80, 1'b0);
      send_byte(CharQuote, 1'b1);
      // NUL before the opening quote, controls, lone and invalid leads
      send_byte(8'h00, 1'b0);
      send_byte(8'h01, 1'b0);
      send_byte(CharDel, 1'b0);
      send_byte(8'h7E, 1'b0);
      send_byte(Cont80, 1'b0);
      send_byte(8'hC1, 1'b0);
      send_byte(LeadMin2, 1'b0);
      send_byte(Cont80, 1'b0);
      // second byte out of range after E0, ED and F4
      send_byte(LeadE0, 1'b0);
      send_byte(8'h9F, 1'b0);
      send_byte(LeadED, 1'b0);
      send_byte(SecA0, 1'b0);
      send_byte(LeadMax4, 1'b0);
      send_byte(Sec90, 1'b0);
      send_byte(8'hEF, 1'b0);
      send_byte(8'hBF, 1'b0);
      send_byte(8'hBF, 1'b0);
      // sequence truncated by the end of the field
      send_byte(8'hE2, 1'b0);
      send_byte(8'h82, 1'b1);
      // field with nothing kept, then a one-byte field
      send_byte(8'h00, 1'b1);
      send_byte(8'hFF, 1'b1);
      push <= 1'b0;
      wait_drained();
   endtask

   task automatic test_random_fields(input int n_bytes, input int tx_pct, input int rx_pct);
      int start_count;
      start_count = bytes_sent;
      tx_idle_pct = tx_pct;
      rx_idle_pct = rx_pct;
      while (bytes_sent - start_count < n_bytes)
         send_random_field();
      push <= 1'b0;
      wait_drained();
   endtask

   // Receiver stops for a long stretch while bytes keep coming
   task automatic test_backpressure();
      int start_count;
      start_count = bytes_sent;
      tx_idle_pct = 0;
      rx_idle_pct = 0;
      hold_requests++;
      while (bytes_sent - start_count < 40)
         send_random_field();
      push <= 1'b0;
      wait_drained();
   endtask

   // Result checker and pop driver
   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         if (pop && !empty) begin
            if (quoted_out_q.size() == 0) begin
               $error("unexpected result: out_byte %02h", rsp_data.out_byte);
               errors++;
            end else begin
               want = quoted_out_q.pop_front();
               if (rsp_data.out_byte !== want.out_byte) begin
                  $error("out_byte: expected %02h, actual %02h",
                         want.out_byte, rsp_data.out_byte);
                  errors++;
               end
               if (rsp_data.run_last !== want.run_last) begin
                  $error("run_last: expected %0b, actual %0b",
                         want.run_last, rsp_data.run_last);
                  errors++;
               end
               if (rsp_data.field_done !== want.field_done) begin
                  $error("field_done: expected %0b, actual %0b",
                         want.field_done, rsp_data.field_done);
                  errors++;
               end
               bytes_checked++;
            end
         end
         if (hold_requests != holds_served) begin
            holds_served = hold_requests;
            rx_hold_left = HoldOffCycles;
         end
         if (rx_hold_left > 0) begin
            rx_hold_left--;
            pop <= 1'b0;
         end else begin
            pop <= ($urandom_range(99) >= rx_idle_pct);
         end
      end
   end

   // Watchdog: cycles in a row with no transaction on either side
   always @(posedge clock) begin
      if ((push && !full) || (pop && !empty))
         stall_cycles = 0;
      else
         stall_cycles++;
      if (stall_cycles >= WatchdogLimit) begin
         $display("watchdog: no transaction for %0d cycles", stall_cycles);
         $display("Regression FAIL");
         $finish;
      end
   end

   initial begin
      clear_field_state();
      repeat (ResetCycles) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_random_fields(95, 38, 51);
      test_random_fields(95, 51, 38);
      test_random_fields(95, 0, 0);
      test_backpressure();

      wait_drained();
      repeat (DrainCycles) @(posedge clock);
      if (quoted_out_q.size() != 0) begin
         $error("%0d expected results never arrived", quoted_out_q.size());
         errors++;
      end
      $display("Sent %0d bytes in %0d fields; %0d output bytes checked.",
               bytes_sent, fields_sent, bytes_checked);
      $display("Covered valid and malformed UTF-8, quoting, controls and a long stall.");
      if (errors == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

`default_nettype wire
